>>> rtl/core/secded_pkg.sv
// Shared constants, types and code-layout functions for the SECDED check-and-correct block.
// Used by secded_encode, secded_correct and secded_32bit_check_correct; depends on nothing.
package secded_pkg;

	localparam int WORD_W = 32;
	localparam int CHECK_W = 6;
	localparam int STATUS_W = 2;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FIRST_POS = 3;
	localparam int FIRST_SKIP = 4;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_OK = 2'd0;
	localparam status_t ST_SINGLE = 2'd1;
	localparam status_t ST_DOUBLE = 2'd2;

	typedef struct packed {
		logic [CHECK_W-1:0] check;
		logic parity;
	} enc_t;

	// Codeword position of data bit idx: the idx-th position of three or more
	// that is not a power of two.
	function automatic int position_of(input int idx);
		int pos;
		int skip;
		pos = FIRST_POS;
		skip = FIRST_SKIP;
		for (int i = 0; i < idx; i++) begin
			pos = pos + 1;
			if (pos == skip) begin
				pos = pos + 1;
				skip = skip * 2;
			end
		end
		return pos;
	endfunction

	// Data bits that feed check bit k.
	function automatic logic [WORD_W-1:0] check_mask(input int k, input int dw);
		logic [WORD_W-1:0] m;
		int p;
		m = '0;
		for (int i = 0; i < WORD_W; i++) begin
			p = position_of(i);
			if (i < dw && ((p >> k) & 1) == 1) begin
				m[i] = 1'b1;
			end
		end
		return m;
	endfunction

	// Data bits that exist at the configured data width.
	function automatic logic [WORD_W-1:0] data_mask(input int dw);
		logic [WORD_W-1:0] m;
		m = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (i < dw) begin
				m[i] = 1'b1;
			end
		end
		return m;
	endfunction

endpackage

>>> rtl/core/secded_encode.sv
// XOR trees that compute the check bits and overall parity of one data word.
// Depends on secded_pkg.
module secded_encode #(
	parameter int DATA_WIDTH = secded_pkg::DATA_WIDTH_DEF
) (
	input  logic [secded_pkg::WORD_W-1:0] data,
	output secded_pkg::enc_t              enc
);
	import secded_pkg::*;

	logic [CHECK_W-1:0] check;

	for (genvar k = 0; k < CHECK_W; k++) begin : g_check
		localparam logic [WORD_W-1:0] MASK = check_mask(k, DATA_WIDTH);
		assign check[k] = ^(data & MASK);
	end

	assign enc.check = check;
	assign enc.parity = (^data) ^ (^check);

endmodule

>>> rtl/core/secded_correct.sv
// Syndrome decode, single-bit correction and status for one checked word.
// Depends on secded_pkg.
module secded_correct #(
	parameter int DATA_WIDTH = secded_pkg::DATA_WIDTH_DEF
) (
	input  logic [secded_pkg::WORD_W-1:0]  data,
	input  logic [secded_pkg::CHECK_W-1:0] stored_check,
	input  logic                           stored_parity,
	input  secded_pkg::enc_t               enc,
	output logic [secded_pkg::WORD_W-1:0]  corrected,
	output secded_pkg::status_t            status
);
	import secded_pkg::*;

	logic [CHECK_W-1:0] syndrome;
	logic parity_err;
	logic [WORD_W-1:0] flip;

	assign syndrome = stored_check ^ enc.check;
	assign parity_err = stored_parity ^ enc.parity;

	for (genvar i = 0; i < WORD_W; i++) begin : g_flip
		if (i < DATA_WIDTH) begin : g_live
			localparam logic [CHECK_W-1:0] POS = CHECK_W'(position_of(i));
			assign flip[i] = parity_err && (syndrome == POS);
		end else begin : g_dead
			assign flip[i] = 1'b0;
		end
	end

	assign corrected = data ^ flip;

	always_comb begin
		if (parity_err) begin
			status = ST_SINGLE;
		end else if (syndrome != '0) begin
			status = ST_DOUBLE;
		end else begin
			status = ST_OK;
		end
	end

endmodule

>>> rtl/core/secded_32bit_check_correct.sv
// Top level of the SECDED check-and-correct block: input register, encode and correct logic,
// result register. Depends on secded_pkg, secded_encode and secded_correct.
//
// The block takes one word per clock cycle and never raises busy. A word accepted at a rising
// edge (start high, busy low) is registered, its check bits, parity and syndrome are computed
// by XOR trees and compares, and the result is registered, which raises done; done stays high
// for one cycle, and the result with check_bits, parity_bit, corrected_word and status is
// valid while done is high. The receiver cannot stall the block, so the result must be taken
// in the cycle that done marks it. Status is 0 for a clean word, 1 when the parity differs
// (the named data bit is flipped; a syndrome naming a check or parity position leaves the
// data as it was), and 2 for a double error, in which case the data passes unchanged.
module secded_32bit_check_correct #(
	parameter int DATA_WIDTH = secded_pkg::DATA_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [secded_pkg::WORD_W-1:0]  data_word,
	input  logic [secded_pkg::CHECK_W-1:0] stored_check,
	input  logic                           stored_parity,
	output logic                           done,
	output logic [secded_pkg::CHECK_W-1:0] check_bits,
	output logic                           parity_bit,
	output logic [secded_pkg::WORD_W-1:0]  corrected_word,
	output secded_pkg::status_t            status
);
	import secded_pkg::*;

	localparam logic [WORD_W-1:0] DMASK = data_mask(DATA_WIDTH);

	logic accept;
	logic valid_s1;
	logic [WORD_W-1:0] data_s1;
	logic [CHECK_W-1:0] check_s1;
	logic parity_s1;
	enc_t enc;
	logic [WORD_W-1:0] corrected;
	status_t status_c;
	logic valid_s2;
	logic [CHECK_W-1:0] check_s2;
	logic parity_s2;
	logic [WORD_W-1:0] corrected_s2;
	status_t status_s2;

	assign busy = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= data_word & DMASK;
			check_s1 <= stored_check;
			parity_s1 <= stored_parity;
		end
		if (valid_s1) begin
			check_s2 <= enc.check;
			parity_s2 <= enc.parity;
			corrected_s2 <= corrected;
			status_s2 <= status_c;
		end
	end

	secded_encode #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_encode (
		.data(data_s1),
		.enc (enc)
	);

	secded_correct #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_correct (
		.data         (data_s1),
		.stored_check (check_s1),
		.stored_parity(parity_s1),
		.enc          (enc),
		.corrected    (corrected),
		.status       (status_c)
	);

	assign done = valid_s2;
	assign check_bits = check_s2;
	assign parity_bit = parity_s2;
	assign corrected_word = corrected_s2;
	assign status = status_s2;

	// Every accepted word produces a result.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 done)
		else $error("accepted word did not produce a result");

	// A result never carries an unused status code.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_SINGLE || status == ST_DOUBLE))
		else $error("result carries an unused status code");

	// Only a single-error result may differ from the registered data word.
	a_pass_through: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_SINGLE |-> corrected_word == $past(data_s1))
		else $error("word changed without a single error");

	// Correction flips at most one bit.
	a_one_flip: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_SINGLE |-> $countones(corrected_word ^ $past(data_s1)) <= 1)
		else $error("correction flipped more than one bit");

endmodule

>>> dv/secded_32bit_check_correct_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for secded_32bit_check_correct: a directed table, then random
// codewords with injected single, double and noise errors, checked by a SECDED decoder model.
// Depends on secded_pkg and secded_32bit_check_correct.
module secded_32bit_check_correct_test;

	localparam int CODE_W = secded_pkg::WORD_W + secded_pkg::CHECK_W + 1;
	localparam int RANDOM_WORDS = 1250;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [secded_pkg::CHECK_W-1:0] check;
		logic parity;
		logic [secded_pkg::WORD_W-1:0] word;
		secded_pkg::status_t status;
	} decode_result_t;

	typedef struct packed {
		logic [secded_pkg::WORD_W-1:0] data;
		logic [secded_pkg::CHECK_W-1:0] chk;
		logic par;
		logic typed;
		decode_result_t want;
	} directed_row_t;

	localparam int DIRECTED_N = 20;
	localparam directed_row_t DIRECTED_ROWS [DIRECTED_N] = '{
		'{32'h0000_0000, 6'd0, 1'b0, 1'b1, '{6'd0, 1'b0, 32'h0000_0000, secded_pkg::ST_OK}},
		'{32'h0000_0001, 6'd3, 1'b1, 1'b1, '{6'd3, 1'b1, 32'h0000_0001, secded_pkg::ST_OK}},
		'{32'h0000_0000, 6'd3, 1'b1, 1'b1, '{6'd0, 1'b0, 32'h0000_0001, secded_pkg::ST_SINGLE}},
		'{32'h0000_0000, 6'd38, 1'b1, 1'b1, '{6'd0, 1'b0, 32'h8000_0000, secded_pkg::ST_SINGLE}},
		'{32'h0000_0000, 6'd0, 1'b1, 1'b1, '{6'd0, 1'b0, 32'h0000_0000, secded_pkg::ST_SINGLE}},
		'{32'h0000_0000, 6'd1, 1'b1, 1'b1, '{6'd0, 1'b0, 32'h0000_0000, secded_pkg::ST_SINGLE}},
		'{32'h0000_0000, 6'd32, 1'b1, 1'b1, '{6'd0, 1'b0, 32'h0000_0000, secded_pkg::ST_SINGLE}},
		'{32'h0000_0000, 6'd39, 1'b1, 1'b1, '{6'd0, 1'b0, 32'h0000_0000, secded_pkg::ST_SINGLE}},
		'{32'h0000_0000, 6'd63, 1'b1, 1'b1, '{6'd0, 1'b0, 32'h0000_0000, secded_pkg::ST_SINGLE}},
		'{32'h0000_0000, 6'd5, 1'b0, 1'b1, '{6'd0, 1'b0, 32'h0000_0000, secded_pkg::ST_DOUBLE}},
		'{32'h0000_0000, 6'd63, 1'b0, 1'b1, '{6'd0, 1'b0, 32'h0000_0000, secded_pkg::ST_DOUBLE}},
		'{32'h0000_0001, 6'd0, 1'b0, 1'b1, '{6'd3, 1'b1, 32'h0000_0000, secded_pkg::ST_SINGLE}},
		'{32'h8000_0000, 6'd38, 1'b0, 1'b1, '{6'd38, 1'b0, 32'h8000_0000, secded_pkg::ST_OK}},
		'{32'h8000_0000, 6'd0, 1'b1, 1'b1, '{6'd38, 1'b0, 32'h0000_0000, secded_pkg::ST_SINGLE}},
		'{32'hFFFF_FFFF, 6'd0, 1'b0, 1'b0, '0},
		'{32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0, '0},
		'{32'hAAAA_AAAA, 6'd21, 1'b1, 1'b0, '0},
		'{32'h5555_5555, 6'd42, 1'b0, 1'b0, '0},
		'{32'hFFFF_0000, 6'd21, 1'b1, 1'b0, '0},
		'{32'h0000_FFFF, 6'd42, 1'b0, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [secded_pkg::WORD_W-1:0] data_word = '0;
	logic [secded_pkg::CHECK_W-1:0] stored_check = '0;
	logic stored_parity = 1'b0;
	logic done;
	logic [secded_pkg::CHECK_W-1:0] check_bits;
	logic parity_bit;
	logic [secded_pkg::WORD_W-1:0] corrected_word;
	secded_pkg::status_t status;

	decode_result_t pending_decodes[$];
	int error_count = 0;
	int cycle_count = 0;

	secded_32bit_check_correct i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.data_word(data_word),
		.stored_check(stored_check),
		.stored_parity(stored_parity),
		.done(done),
		.check_bits(check_bits),
		.parity_bit(parity_bit),
		.corrected_word(corrected_word),
		.status(status)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Position of data bit idx in the codeword: counting from 3 and skipping powers of two.
	function automatic int code_position(input int idx);
		int p;
		int n;
		p = 2;
		n = -1;
		while (n < idx) begin
			p++;
			if ((p & (p - 1)) != 0) begin
				n++;
			end
		end
		return p;
	endfunction

	function automatic decode_result_t secded_decode(input logic [secded_pkg::WORD_W-1:0] data,
		input logic [secded_pkg::CHECK_W-1:0] schk, input logic spar);
		decode_result_t r;
		logic [secded_pkg::CHECK_W-1:0] syndrome;
		r.check = '0;
		for (int i = 0; i < secded_pkg::WORD_W; i++) begin
			if (data[i]) begin
				r.check = r.check ^ secded_pkg::CHECK_W'(code_position(i));
			end
		end
		r.parity = (^data) ^ (^r.check);
		r.word = data;
		if (spar == r.parity) begin
			r.status = (schk == r.check) ? secded_pkg::ST_OK : secded_pkg::ST_DOUBLE;
		end else begin
			r.status = secded_pkg::ST_SINGLE;
			syndrome = schk ^ r.check;
			for (int i = 0; i < secded_pkg::WORD_W; i++) begin
				if (code_position(i) == syndrome) begin
					r.word[i] = ~r.word[i];
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("cycle %0d: %s mismatch, got %h expected %h", cycle_count, what, got, want);
		error_count++;
	endtask

	task automatic send_word(input logic [secded_pkg::WORD_W-1:0] data,
		input logic [secded_pkg::CHECK_W-1:0] chk, input logic par, input logic typed,
		input decode_result_t want);
		data_word <= data;
		stored_check <= chk;
		stored_parity <= par;
		start <= 1'b1;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		pending_decodes.push_back(typed ? want : secded_decode(data, chk, par));
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_decodes.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic send_random_word();
		logic [CODE_W-1:0] cw;
		logic [secded_pkg::WORD_W-1:0] data;
		decode_result_t enc;
		int kind;
		int a;
		int b;
		case ($urandom_range(0, 9))
			0: data = '0;
			1: data = '1;
			2: data = 32'h1 << $urandom_range(0, 31);
			3: data = ~(32'h1 << $urandom_range(0, 31));
			default: data = $urandom;
		endcase
		enc = secded_decode(data, '0, 1'b0);
		cw = {enc.parity, enc.check, data};
		kind = $urandom_range(0, 99);
		if (kind < 20) begin
		end else if (kind < 50) begin
			cw[$urandom_range(0, CODE_W - 1)] ^= 1'b1;
		end else if (kind < 80) begin
			a = $urandom_range(0, CODE_W - 1);
			b = (a + $urandom_range(1, CODE_W - 1)) % CODE_W;
			cw[a] ^= 1'b1;
			cw[b] ^= 1'b1;
		end else begin
			cw[CODE_W-1:secded_pkg::WORD_W] = (CODE_W - secded_pkg::WORD_W)'($urandom);
		end
		send_word(cw[secded_pkg::WORD_W-1:0], cw[CODE_W-2:secded_pkg::WORD_W], cw[CODE_W-1],
			1'b0, '0);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("secded_32bit_check_correct regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		decode_result_t want;
		if (arst_n && done) begin
			if (pending_decodes.size() == 0) begin
				report_mismatch("unexpected word", corrected_word, '0);
			end else begin
				want = pending_decodes.pop_front();
				if (check_bits !== want.check) begin
					report_mismatch("check_bits", 32'(check_bits), 32'(want.check));
				end
				if (parity_bit !== want.parity) begin
					report_mismatch("parity_bit", 32'(parity_bit), 32'(want.parity));
				end
				if (corrected_word !== want.word) begin
					report_mismatch("corrected_word", corrected_word, want.word);
				end
				if (status !== want.status) begin
					report_mismatch("status", 32'(status), 32'(want.status));
				end
			end
		end
	end

	initial begin
		int burst_left;
		int gap;
		burst_left = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		for (int r = 0; r < DIRECTED_N; r++) begin
			send_word(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].chk, DIRECTED_ROWS[r].par,
				DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
		end
		drain_results();
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == 400 || n == 900) begin
				drain_results();
			end
			if (burst_left == 0 && (n < 600 || n >= 750)) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap != 0) begin
					idle_cycles(gap);
				end
				burst_left = $urandom_range(1, 40);
			end
			send_random_word();
			if (burst_left != 0) begin
				burst_left--;
			end
		end
		start <= 1'b0;
		while (pending_decodes.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("secded_32bit_check_correct regression: pass");
		end else begin
			$display("secded_32bit_check_correct regression: fail");
		end
		$finish;
	end

endmodule
